// ===== design/rdac_pkg.sv =====
package rdac_pkg;

  // Register select codes
  localparam logic [2:0] SEL_VGA_IDX   = 3'd2;
  localparam logic [2:0] SEL_WR_INDEX  = 3'd4;
  localparam logic [2:0] SEL_EXT_DATA  = 3'd5;
  localparam logic [2:0] SEL_COMMAND   = 3'd6;
  localparam logic [2:0] SEL_RD_INDEX  = 3'd7;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Hidden-access sequence counts
  localparam logic [2:0] HC_IDLE   = 3'd0;
  localparam logic [2:0] HC_ONE    = 3'd1;
  localparam logic [2:0] HC_TWO    = 3'd2;
  localparam logic [2:0] HC_THREE  = 3'd3;
  localparam logic [2:0] HC_OPEN   = 3'd4;

  // Fixed extended register values and ID bytes
  localparam logic [15:0] EXT_ID0     = 16'h6128;
  localparam logic [15:0] EXT_ID1     = 16'h623d;
  localparam logic [7:0]  FLAVOR_ID   = 8'h70;
  localparam logic [15:0] HI_MASK     = 16'hff00;
  localparam logic [15:0] LO_MASK     = 16'h00ff;

  localparam logic [3:0]  CHIP_TYPE_RST = 4'd8;
  localparam int          NUM_CLK_REGS  = 8;

  // Pixel depth codes
  localparam logic [2:0] DEPTH_8  = 3'd0;
  localparam logic [2:0] DEPTH_15 = 3'd1;
  localparam logic [2:0] DEPTH_16 = 3'd2;
  localparam logic [2:0] DEPTH_24 = 3'd3;
  localparam logic [2:0] DEPTH_32 = 3'd4;

  typedef struct packed {
    logic [7:0] read_data;
    logic       forwarded;
    logic       mode_update;
    logic [2:0] depth_code;
  } rdac_result_t;

  // Slot of a writable extended register index
  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
  } rdac_slot_t;

  function automatic rdac_slot_t slot_of(input logic [7:0] idx);
    rdac_slot_t s;
    s.valid = 1'b1;
    s.slot  = 3'd0;
    if (idx >= 8'd2 && idx <= 8'd7) begin
      s.slot = 3'(idx - 8'd2);
    end else if (idx == 8'h0a) begin
      s.slot = 3'd6;
    end else if (idx == 8'h0e) begin
      s.slot = 3'd7;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  // Command byte to depth code, per chip variant
  function automatic logic [2:0] decode_depth(input logic [2:0] variant,
                                              input logic [7:0] val);
    logic [2:0] d;
    d = DEPTH_8;
    if (variant <= 3'd1) begin
      case (val[7:5]) inside
        3'd1, 3'd4, 3'd5: d = DEPTH_15;
        3'd3, 3'd6:       d = DEPTH_16;
        3'd2, 3'd7:       d = DEPTH_24;
        default:          d = DEPTH_8;
      endcase
    end else if (variant <= 3'd4) begin
      case (val[7:4]) inside
        4'd2, 4'd3, 4'd8, 4'd10: d = DEPTH_15;
        4'd5, 4'd6, 4'd12:       d = DEPTH_16;
        4'd4, 4'd9, 4'd14:       d = DEPTH_24;
        4'd7:                    d = DEPTH_32;
        default:                 d = DEPTH_8;
      endcase
    end
    return d;
  endfunction

endpackage

// ===== design/rdac_core.sv =====
module rdac_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  access,
  input  logic                  cmd,
  input  logic [2:0]            reg_select,
  input  logic [7:0]            write_data,
  input  logic [7:0]            vga_read_data,
  input  logic [3:0]            chip_type,
  output rdac_pkg::rdac_result_t result
);
  import rdac_pkg::*;

  logic [15:0] clock_regs_r [NUM_CLK_REGS];
  logic [15:0] clock_regs_nxt [NUM_CLK_REGS];
  logic [7:0]  write_index_r, write_index_nxt;
  logic [7:0]  read_index_r, read_index_nxt;
  logic        byte_phase_r, byte_phase_nxt;
  logic [2:0]  hidden_count_r, hidden_count_nxt;
  logic [7:0]  command_reg_r, command_reg_nxt;

  logic [2:0]  hc_eff;
  rdac_slot_t  wr_slot, rd_slot;
  logic [15:0] ext_rd;
  logic [15:0] ext_wr;

  assign wr_slot = slot_of(write_index_r);
  assign rd_slot = slot_of(read_index_r);

  // Extended register read value at the read index
  always_comb begin
    if (rd_slot.valid) begin
      ext_rd = clock_regs_r[rd_slot.slot];
    end else if (read_index_r == 8'd0) begin
      ext_rd = EXT_ID0;
    end else if (read_index_r == 8'd1) begin
      ext_rd = EXT_ID1;
    end else begin
      ext_rd = 16'd0;
    end
  end

  // Merged write value for the addressed clock register
  always_comb begin
    if (!byte_phase_r) begin
      ext_wr = (clock_regs_r[wr_slot.slot] & HI_MASK) | {8'd0, write_data};
    end else begin
      ext_wr = (clock_regs_r[wr_slot.slot] & LO_MASK) | {write_data, 8'd0};
    end
  end

  // Per-access decode and state update
  always_comb begin
    hc_eff           = (reg_select != SEL_VGA_IDX) ? HC_IDLE : hidden_count_r;
    clock_regs_nxt   = clock_regs_r;
    write_index_nxt  = write_index_r;
    read_index_nxt   = read_index_r;
    byte_phase_nxt   = byte_phase_r;
    hidden_count_nxt = hc_eff;
    command_reg_nxt  = command_reg_r;
    result           = '0;

    if (cmd == CMD_WRITE) begin
      case (reg_select)
        SEL_VGA_IDX: begin
          if (hc_eff == HC_OPEN) begin
            command_reg_nxt    = write_data;
            result.mode_update = 1'b1;
            result.depth_code  = decode_depth(chip_type[2:0], write_data);
            hidden_count_nxt   = HC_IDLE;
          end else begin
            result.forwarded = 1'b1;
          end
        end
        SEL_WR_INDEX: begin
          write_index_nxt = write_data;
          byte_phase_nxt  = 1'b0;
        end
        SEL_EXT_DATA: begin
          if (wr_slot.valid) begin
            clock_regs_nxt[wr_slot.slot] = ext_wr;
          end
          byte_phase_nxt = ~byte_phase_r;
          if (byte_phase_r) begin
            write_index_nxt = write_index_r + 8'd1;
          end
        end
        SEL_COMMAND: begin
          command_reg_nxt    = write_data;
          result.mode_update = 1'b1;
          result.depth_code  = decode_depth(chip_type[2:0], write_data);
        end
        SEL_RD_INDEX: begin
          read_index_nxt = write_data;
          byte_phase_nxt = 1'b0;
        end
        default: begin
          result.forwarded = 1'b1;
        end
      endcase
    end else begin
      case (reg_select)
        SEL_VGA_IDX: begin
          case (hc_eff)
            HC_ONE, HC_TWO: begin
              hidden_count_nxt = hc_eff + 3'd1;
            end
            HC_THREE: begin
              result.read_data = chip_type[3] ? FLAVOR_ID : 8'd0;
              hidden_count_nxt = hc_eff + 3'd1;
            end
            HC_OPEN: begin
              result.read_data = command_reg_r;
              hidden_count_nxt = HC_IDLE;
            end
            default: begin
              result.read_data = vga_read_data;
              result.forwarded = 1'b1;
              hidden_count_nxt = hc_eff + 3'd1;
            end
          endcase
        end
        SEL_WR_INDEX: result.read_data = write_index_r;
        SEL_EXT_DATA: begin
          result.read_data = byte_phase_r ? ext_rd[15:8] : ext_rd[7:0];
          byte_phase_nxt   = ~byte_phase_r;
          if (byte_phase_r) begin
            read_index_nxt = read_index_r + 8'd1;
          end
        end
        SEL_COMMAND:  result.read_data = command_reg_r;
        SEL_RD_INDEX: result.read_data = read_index_r;
        default: begin
          result.read_data = vga_read_data;
          result.forwarded = 1'b1;
        end
      endcase
    end
  end

  // State registers, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CLK_REGS; i++) begin
        clock_regs_r[i] <= '0;
      end
      write_index_r  <= '0;
      read_index_r   <= '0;
      byte_phase_r   <= 1'b0;
      hidden_count_r <= HC_IDLE;
      command_reg_r  <= '0;
    end else if (access) begin
      clock_regs_r   <= clock_regs_nxt;
      write_index_r  <= write_index_nxt;
      read_index_r   <= read_index_nxt;
      byte_phase_r   <= byte_phase_nxt;
      hidden_count_r <= hidden_count_nxt;
      command_reg_r  <= command_reg_nxt;
    end
  end

endmodule

// ===== design/ramdac_extended_register_port.sv =====
// A result beat is registered in the output register, or in the skid stage if stalled.
// Throughput: one access per cycle while the skid stage is empty; register state is
// updated in the accept cycle, so the next access sees it right away. A skid stage
// behind the output register keeps in_ready high while one result waits on out_ready.
// Reset (rst_n low, synchronous): all registers, indexes, byte phase, hidden count
// and command byte clear to zero; chip_type returns to 8; output stage empties.
module ramdac_extended_register_port (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_chip_type,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [2:0] in_reg_select,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_vga_read_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_forwarded,
  output logic       out_mode_update,
  output logic [2:0] out_depth_code
);
  import rdac_pkg::*;

  logic         chip_type_r;
  logic [3:0]   chip_type_q_r;
  logic         in_fire;
  rdac_result_t core_res;
  rdac_result_t out_data_r, skid_data_r;
  logic         out_valid_r, skid_valid_r;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_type_q_r <= CHIP_TYPE_RST;
      chip_type_r   <= 1'b0;
    end else if (cfg_valid) begin
      chip_type_q_r <= cfg_chip_type;
      chip_type_r   <= 1'b1;
    end
  end

  assign in_ready = ~skid_valid_r;
  assign in_fire  = in_valid & in_ready;

  rdac_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .access        (in_fire),
    .cmd           (in_cmd),
    .reg_select    (in_reg_select),
    .write_data    (in_write_data),
    .vga_read_data (in_vga_read_data),
    .chip_type     (chip_type_q_r),
    .result        (core_res)
  );

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : core_res;
    end else if (in_fire) begin
      skid_data_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r.read_data;
  assign out_forwarded   = out_data_r.forwarded;
  assign out_mode_update = out_data_r.mode_update;
  assign out_depth_code  = out_data_r.depth_code;

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while output register is empty");

  a_depth_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_depth_code != DEPTH_8 |-> out_mode_update)
    else $error("depth code reported without a command write");

  a_update_not_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mode_update |-> !out_forwarded && out_read_data == 8'd0)
    else $error("command write flagged as forwarded or returned data");

  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> chip_type_r && chip_type_q_r == $past(cfg_chip_type))
    else $error("configuration beat not captured");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import rdac_pkg::*;

  // Selects that only go to the VGA core
  localparam logic [2:0] SEL_DAC_WIDX = 3'd0;
  localparam logic [2:0] SEL_DAC_DATA = 3'd1;
  localparam logic [2:0] SEL_DAC_RIDX = 3'd3;

  // Extended register indexes with storage behind them
  localparam logic [7:0] EXT_IDX_FIRST = 8'h02;
  localparam logic [7:0] EXT_IDX_LAST  = 8'h07;
  localparam logic [7:0] EXT_IDX_A     = 8'h0a;
  localparam logic [7:0] EXT_IDX_E     = 8'h0e;
  localparam int         SLOT_IDX_A    = 6;
  localparam int         SLOT_IDX_E    = 7;

  // Chip variant groups for depth decode
  localparam logic [2:0] VAR_NARROW_MAX = 3'd1;
  localparam logic [2:0] VAR_WIDE_MAX   = 3'd4;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  logic       clk;
  logic       rst_n;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_chip_type;
  logic       in_valid;
  logic       in_ready;
  logic       in_cmd;
  logic [2:0] in_reg_select;
  logic [7:0] in_write_data;
  logic [7:0] in_vga_read_data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_read_data;
  logic       out_forwarded;
  logic       out_mode_update;
  logic [2:0] out_depth_code;

  ramdac_extended_register_port dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_chip_type    (cfg_chip_type),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_reg_select    (in_reg_select),
    .in_write_data    (in_write_data),
    .in_vga_read_data (in_vga_read_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_forwarded    (out_forwarded),
    .out_mode_update  (out_mode_update),
    .out_depth_code   (out_depth_code)
  );

  // Clock: 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Shadow copy of the port's register state
  logic [15:0] clk_reg_m [NUM_CLK_REGS];
  logic [7:0]  wr_index_m;
  logic [7:0]  rd_index_m;
  logic        hi_byte_m;
  logic [2:0]  hidden_m;
  logic [7:0]  command_m;
  logic [3:0]  chip_m;

  rdac_result_t access_results_due [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int n_sent;
  int n_accepted;
  int n_errors;
  int n_fwd;
  int n_mode;
  int n_unlocks;
  int n_cfg;
  int stall_cycles;
  int step;
  int chip_plan [16] = '{0, 15, 1, 2, 3, 4, 5, 6, 7, 9, 10, 11, 12, 13, 14, 8};

  function automatic void reset_shadow();
    for (int k = 0; k < NUM_CLK_REGS; k++) clk_reg_m[k] = '0;
    wr_index_m = '0;
    rd_index_m = '0;
    hi_byte_m  = 1'b0;
    hidden_m   = HC_IDLE;
    command_m  = '0;
    chip_m     = CHIP_TYPE_RST;
  endfunction

  // Storage slot behind an extended index, -1 if none
  function automatic int ext_slot(input logic [7:0] idx);
    if (idx >= EXT_IDX_FIRST && idx <= EXT_IDX_LAST) return int'(idx - EXT_IDX_FIRST);
    if (idx == EXT_IDX_A) return SLOT_IDX_A;
    if (idx == EXT_IDX_E) return SLOT_IDX_E;
    return -1;
  endfunction

  function automatic logic [2:0] pixel_depth(input logic [7:0] b);
    logic [2:0] variant;
    logic [2:0] d;
    variant = chip_m[2:0];
    d = DEPTH_8;
    if (variant <= VAR_NARROW_MAX) begin
      case (b[7:5])
        3'd1, 3'd4, 3'd5: d = DEPTH_15;
        3'd3, 3'd6:       d = DEPTH_16;
        3'd2, 3'd7:       d = DEPTH_24;
        default:          d = DEPTH_8;
      endcase
    end else if (variant <= VAR_WIDE_MAX) begin
      case (b[7:4])
        4'd2, 4'd3, 4'd8, 4'd10: d = DEPTH_15;
        4'd5, 4'd6, 4'd12:       d = DEPTH_16;
        4'd4, 4'd9, 4'd14:       d = DEPTH_24;
        4'd7:                    d = DEPTH_32;
        default:                 d = DEPTH_8;
      endcase
    end
    return d;
  endfunction

  // Apply one bus access to the shadow state and return its result beat
  function automatic rdac_result_t predict_access(input logic c, input logic [2:0] s,
                                                  input logic [7:0] w, input logic [7:0] v);
    rdac_result_t r;
    int slot;
    logic [15:0] word;
    r = '0;
    if (s != SEL_VGA_IDX) hidden_m = HC_IDLE;
    if (c == CMD_WRITE) begin
      case (s)
        SEL_VGA_IDX: begin
          if (hidden_m == HC_OPEN) begin
            command_m     = w;
            r.mode_update = 1'b1;
            r.depth_code  = pixel_depth(w);
            hidden_m      = HC_IDLE;
            n_unlocks++;
          end else begin
            r.forwarded = 1'b1;
          end
        end
        SEL_WR_INDEX: begin
          wr_index_m = w;
          hi_byte_m  = 1'b0;
        end
        SEL_EXT_DATA: begin
          slot = ext_slot(wr_index_m);
          if (slot >= 0) begin
            if (hi_byte_m) clk_reg_m[slot] = {w, clk_reg_m[slot][7:0]};
            else clk_reg_m[slot] = {clk_reg_m[slot][15:8], w};
          end
          hi_byte_m = ~hi_byte_m;
          if (!hi_byte_m) wr_index_m = wr_index_m + 8'd1;
        end
        SEL_COMMAND: begin
          command_m     = w;
          r.mode_update = 1'b1;
          r.depth_code  = pixel_depth(w);
        end
        SEL_RD_INDEX: begin
          rd_index_m = w;
          hi_byte_m  = 1'b0;
        end
        default: r.forwarded = 1'b1;
      endcase
    end else begin
      case (s)
        SEL_VGA_IDX: begin
          case (hidden_m)
            HC_ONE, HC_TWO: begin
              r.read_data = 8'h00;
              hidden_m    = hidden_m + 3'd1;
            end
            HC_THREE: begin
              r.read_data = chip_m[3] ? FLAVOR_ID : 8'h00;
              hidden_m    = hidden_m + 3'd1;
            end
            HC_OPEN: begin
              r.read_data = command_m;
              hidden_m    = HC_IDLE;
            end
            default: begin
              r.read_data = v;
              r.forwarded = 1'b1;
              hidden_m    = hidden_m + 3'd1;
            end
          endcase
        end
        SEL_WR_INDEX: r.read_data = wr_index_m;
        SEL_EXT_DATA: begin
          slot = ext_slot(rd_index_m);
          if (slot >= 0) word = clk_reg_m[slot];
          else if (rd_index_m == 8'h00) word = EXT_ID0;
          else if (rd_index_m == 8'h01) word = EXT_ID1;
          else word = '0;
          r.read_data = hi_byte_m ? word[15:8] : word[7:0];
          hi_byte_m = ~hi_byte_m;
          if (!hi_byte_m) rd_index_m = rd_index_m + 8'd1;
        end
        SEL_COMMAND:  r.read_data = command_m;
        SEL_RD_INDEX: r.read_data = rd_index_m;
        default: begin
          r.read_data = v;
          r.forwarded = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: check result beats, predict accepted beats, watchdog
  always @(posedge clk) begin
    rdac_result_t got;
    rdac_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_read_data, out_forwarded, out_mode_update, out_depth_code};
        if (got.forwarded) n_fwd++;
        if (got.mode_update) n_mode++;
        if (access_results_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected result beat: rd %02h fwd %0b upd %0b depth %0d",
                     got.read_data, got.forwarded, got.mode_update, got.depth_code);
        end else begin
          want = access_results_due.pop_front();
          if (got.read_data !== want.read_data || got.forwarded !== want.forwarded ||
              got.mode_update !== want.mode_update || got.depth_code !== want.depth_code) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch (exp/got): rd %02h/%02h fwd %0b/%0b upd %0b/%0b depth %0d/%0d",
                       want.read_data, got.read_data, want.forwarded, got.forwarded,
                       want.mode_update, got.mode_update, want.depth_code, got.depth_code);
          end
        end
      end
      if (in_valid && in_ready) begin
        access_results_due.push_back(predict_access(in_cmd, in_reg_select,
                                                    in_write_data, in_vga_read_data));
        n_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        chip_m = cfg_chip_type;
        n_cfg++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one access beat and hold it until accepted
  task automatic send_access(input logic c, input logic [2:0] s,
                             input logic [7:0] w, input logic [7:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= c;
    in_reg_select    <= s;
    in_write_data    <= w;
    in_vga_read_data <= v;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // Stop offering and wait for every pending result
  task automatic pause_until_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (access_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_chip_type(input logic [3:0] t);
    pause_until_done();
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_chip_type <= t;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_ext_index();
    case ($urandom_range(9))
      7, 8:    return 8'($urandom_range(255, 248));
      9:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(15));
    endcase
  endfunction

  // Index and data ports straight out of reset, including the ID words
  task automatic test_reset_values();
    send_access(CMD_READ, SEL_WR_INDEX, 8'h00, 8'hff);
    send_access(CMD_READ, SEL_RD_INDEX, 8'h00, 8'hff);
    send_access(CMD_READ, SEL_COMMAND, 8'h00, 8'hff);
    repeat (4) send_access(CMD_READ, SEL_EXT_DATA, 8'hff, 8'h00);
  endtask

  // Byte phase, index advance, dropped writes and index wrap
  task automatic test_ext_registers();
    send_access(CMD_WRITE, SEL_WR_INDEX, EXT_IDX_E, 8'h00);
    send_access(CMD_WRITE, SEL_EXT_DATA, 8'hff, 8'h00);
    send_access(CMD_WRITE, SEL_EXT_DATA, 8'h00, 8'h00);
    send_access(CMD_WRITE, SEL_RD_INDEX, EXT_IDX_E, 8'h00);
    send_access(CMD_READ, SEL_EXT_DATA, 8'h00, 8'h00);
    send_access(CMD_READ, SEL_EXT_DATA, 8'h00, 8'h00);
    send_access(CMD_WRITE, SEL_WR_INDEX, 8'hff, 8'h00);
    send_access(CMD_WRITE, SEL_EXT_DATA, 8'haa, 8'h00);
    send_access(CMD_WRITE, SEL_EXT_DATA, 8'h55, 8'h00);
    send_access(CMD_READ, SEL_WR_INDEX, 8'h00, 8'h00);
  endtask

  // Four reads at select 2 open the command register, flavour byte on the fourth
  task automatic test_hidden_unlock();
    repeat (4) send_access(CMD_READ, SEL_VGA_IDX, 8'h00, 8'hff);
    send_access(CMD_WRITE, SEL_VGA_IDX, 8'h70, 8'h00);
  endtask

  task automatic test_forwarding();
    send_access(CMD_READ, SEL_DAC_WIDX, 8'hff, 8'h00);
    send_access(CMD_WRITE, SEL_DAC_DATA, 8'hff, 8'hff);
    send_access(CMD_READ, SEL_DAC_RIDX, 8'h00, 8'ha5);
    send_access(CMD_WRITE, SEL_VGA_IDX, 8'h5a, 8'h00);
  endtask

  // Mostly well-formed sequences with random content, some noise
  task automatic run_random_traffic(input int n_items);
    int stop_at;
    int kind;
    int len;
    logic [2:0] sel;
    logic [7:0] idx;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      kind = $urandom_range(9);
      if (kind <= 2) begin
        repeat (4) send_access(CMD_READ, SEL_VGA_IDX, 8'($urandom), 8'($urandom));
        if ($urandom_range(5) == 0) begin
          sel = 3'($urandom_range(7));
          if (sel == SEL_VGA_IDX) sel = SEL_COMMAND;
          send_access(1'($urandom_range(1)), sel, 8'($urandom), 8'($urandom));
        end
        send_access(1'($urandom_range(1)), SEL_VGA_IDX, 8'($urandom), 8'($urandom));
      end else if (kind <= 5) begin
        len = $urandom_range(6, 1);
        idx = rand_ext_index();
        if ($urandom_range(1)) begin
          send_access(CMD_WRITE, SEL_WR_INDEX, idx, 8'($urandom));
          repeat (len) send_access(CMD_WRITE, SEL_EXT_DATA, 8'($urandom), 8'($urandom));
        end else begin
          send_access(CMD_WRITE, SEL_RD_INDEX, idx, 8'($urandom));
          repeat (len) send_access(CMD_READ, SEL_EXT_DATA, 8'($urandom), 8'($urandom));
        end
      end else if (kind == 6) begin
        send_access(CMD_WRITE, SEL_COMMAND, 8'($urandom), 8'($urandom));
        send_access(CMD_READ, SEL_COMMAND, 8'($urandom), 8'($urandom));
      end else begin
        send_access(1'($urandom_range(1)), 3'($urandom_range(7)), 8'($urandom),
                    8'($urandom));
      end
    end
  endtask

  // Receiver holds off while the sender keeps offering; input must stall
  task automatic test_backpressure();
    pause_until_done();
    hold_left = HOLD_CYCLES;
    run_random_traffic(24);
    pause_until_done();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_chip_type    = CHIP_TYPE_RST;
    in_valid         = 1'b0;
    in_cmd           = CMD_READ;
    in_reg_select    = '0;
    in_write_data    = '0;
    in_vga_read_data = '0;
    out_ready        = 1'b0;
    hold_left        = 0;
    send_idle_pct    = 34;
    recv_idle_pct    = 88;
    n_sent           = 0;
    n_accepted       = 0;
    n_errors         = 0;
    n_fwd            = 0;
    n_mode           = 0;
    n_unlocks        = 0;
    n_cfg            = 0;
    stall_cycles     = 0;
    reset_shadow();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_ext_registers();
    test_hidden_unlock();
    test_forwarding();

    // Random traffic under every chip_type, idling pattern switched twice
    for (step = 0; step < 16; step++) begin
      if (step == 6) begin
        send_idle_pct = 88;
        recv_idle_pct = 34;
      end
      if (step == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_chip_type(4'(chip_plan[step]));
      run_random_traffic(23);
    end

    test_backpressure();

    pause_until_done();
    repeat (8) @(posedge clk);
    $display("Covered %0d accesses over %0d chip_type settings: %0d forwarded,",
             n_accepted, n_cfg, n_fwd);
    $display("%0d command writes (%0d through the hidden unlock), %0d errors.",
             n_mode, n_unlocks, n_errors);
    if (n_errors == 0 && access_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rdac_pkg.sv
design/rdac_core.sv
design/ramdac_extended_register_port.sv
tb/tb_top.sv
